>>> design/servo_recipe_sequencer_unit_defines.svh
// Assertion macros shared by the servo recipe sequencer RTL.
`ifndef SERVO_RECIPE_SEQUENCER_UNIT_DEFINES_SVH
`define SERVO_RECIPE_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srs assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define SRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srs assertion failed: next-cycle implication");

`endif

>>> design/srs_pkg.sv
package srs_pkg;

  localparam int unsigned SRS_RECIPE_DEPTH = 64;
  localparam int unsigned SRS_QUEUE_DEPTH  = 2;

  // Transaction command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_KEY   = 2'd2;

  // Key codes (ASCII)
  localparam logic [7:0] KEY_PAUSE_LC    = 8'h70;
  localparam logic [7:0] KEY_PAUSE_UC    = 8'h50;
  localparam logic [7:0] KEY_CONTINUE_LC = 8'h63;
  localparam logic [7:0] KEY_CONTINUE_UC = 8'h43;
  localparam logic [7:0] KEY_RESTART_LC  = 8'h62;
  localparam logic [7:0] KEY_RESTART_UC  = 8'h42;
  localparam logic [7:0] KEY_DOWN_LC     = 8'h72;
  localparam logic [7:0] KEY_DOWN_UC     = 8'h52;
  localparam logic [7:0] KEY_UP_LC       = 8'h6C;
  localparam logic [7:0] KEY_UP_UC       = 8'h4C;

  localparam logic [4:0] ARG_MAX_POSITION = 5'd5;
  localparam logic [2:0] POS_MAX          = 3'd5;
  localparam logic [2:0] POS_MIN          = 3'd0;

  typedef enum logic [2:0] {
    ST_PAUSED   = 3'd0,
    ST_RUNNING  = 3'd1,
    ST_MOVING   = 3'd2,
    ST_CMD_ERR  = 3'd3,
    ST_LOOP_ERR = 3'd4,
    ST_FINISHED = 3'd5,
    ST_FORCED   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    OPC_END     = 3'd0,
    OPC_MOV     = 3'd1,
    OPC_WAIT    = 3'd2,
    OPC_LOOP    = 3'd4,
    OPC_ENDLOOP = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_TICK,
    OP_PAUSE,
    OP_CONTINUE,
    OP_RESTART,
    OP_NUDGE_DOWN,
    OP_NUDGE_UP
  } op_kind_e;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] load_address;
    logic [7:0] load_byte;
    logic [7:0] key;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] servo_position;
    logic [4:0] duty_code;
    logic       green_led;
    logic       red_led;
    logic [5:0] recipe_index;
  } res_item_t;

  // Classified transaction handed from front to back
  typedef struct packed {
    op_kind_e   kind;
    logic [5:0] addr;
    logic [7:0] data;
  } op_t;

  function automatic logic [4:0] duty_of(input logic [2:0] pos);
    logic [4:0] duty;
    case (pos)
      3'd0:    duty = 5'd4;
      3'd1:    duty = 5'd7;
      3'd2:    duty = 5'd10;
      3'd3:    duty = 5'd14;
      3'd4:    duty = 5'd17;
      3'd5:    duty = 5'd20;
      default: duty = 5'd0;
    endcase
    return duty;
  endfunction

endpackage

>>> design/srs_fifo.sv
module srs_fifo import srs_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = SRS_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> design/srs_front.sv
module srs_front import srs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = SRS_QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t item_i,
  output logic     full_o,
  input  logic     op_pop_i,
  output op_t      op_o,
  output logic     op_empty_o
);

  op_t                  op_cls;
  logic [$bits(op_t)-1:0] op_raw;

  // Classify the transaction: decode the key set here so the back sees one op code
  always_comb begin
    op_cls.kind = OP_NONE;
    op_cls.addr = item_i.load_address;
    op_cls.data = item_i.load_byte;
    case (item_i.command)
      CMD_WRITE: op_cls.kind = OP_WRITE;
      CMD_TICK:  op_cls.kind = OP_TICK;
      CMD_KEY: begin
        if (item_i.key inside {KEY_PAUSE_LC, KEY_PAUSE_UC}) begin
          op_cls.kind = OP_PAUSE;
        end else if (item_i.key inside {KEY_CONTINUE_LC, KEY_CONTINUE_UC}) begin
          op_cls.kind = OP_CONTINUE;
        end else if (item_i.key inside {KEY_RESTART_LC, KEY_RESTART_UC}) begin
          op_cls.kind = OP_RESTART;
        end else if (item_i.key inside {KEY_DOWN_LC, KEY_DOWN_UC}) begin
          op_cls.kind = OP_NUDGE_DOWN;
        end else if (item_i.key inside {KEY_UP_LC, KEY_UP_UC}) begin
          op_cls.kind = OP_NUDGE_UP;
        end
      end
      default:   op_cls.kind = OP_NONE;
    endcase
  end

  srs_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (op_cls),
    .full_o  (full_o),
    .pop_i   (op_pop_i),
    .rdata_o (op_raw),
    .empty_o (op_empty_o)
  );

  assign op_o = op_t'(op_raw);

endmodule

>>> design/srs_back.sv
module srs_back import srs_pkg::*; #(
  parameter int unsigned RECIPE_DEPTH = SRS_RECIPE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  op_t       op_i,
  input  logic      op_empty_i,
  output logic      op_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output res_item_t res_o
);

  localparam int unsigned IDX_W = $clog2(RECIPE_DEPTH);

  status_e            status_q, status_d;
  logic [IDX_W-1:0]   idx_q, idx_d, loop_start_q, loop_start_d;
  logic [4:0]         tick_q, tick_d, loop_rem_q, loop_rem_d, duty_q, duty_d;
  logic               loop_act_q, loop_act_d, nudge_q, nudge_d;
  logic               green_q, green_d, red_q, red_d;
  logic [2:0]         pos_q, pos_d;

  logic [7:0]         mem_q [RECIPE_DEPTH];
  logic [RECIPE_DEPTH-1:0] valid_q;
  logic [7:0]         rd_q, fwd_data_q;
  logic               rd_vld_q, fwd_q;

  logic               exec, wr_en;
  logic [IDX_W-1:0]   waddr;
  logic [7:0]         entry;
  logic [2:0]         opc;
  logic [4:0]         arg;
  logic [2:0]         steps;
  logic [4:0]         travel;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(RECIPE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign exec       = !op_empty_i && !res_full_i;
  assign op_pop_o   = exec;
  assign res_push_o = exec;
  assign wr_en      = exec && (op_i.kind == OP_WRITE);
  assign waddr      = IDX_W'(op_i.addr);

  // Entry at the current index, prefetched into a register; a write to it is forwarded
  assign entry = fwd_q ? fwd_data_q : (rd_vld_q ? rd_q : 8'h00);
  assign opc   = entry[7:5];
  assign arg   = entry[4:0];
  assign steps = (arg[2:0] >= pos_q) ? (arg[2:0] - pos_q) : (pos_q - arg[2:0]);
  assign travel = {1'b0, steps, 1'b0};

  always_comb begin
    status_d     = status_q;
    idx_d        = idx_q;
    loop_start_d = loop_start_q;
    tick_d       = tick_q;
    loop_rem_d   = loop_rem_q;
    loop_act_d   = loop_act_q;
    nudge_d      = nudge_q;
    green_d      = green_q;
    red_d        = red_q;
    pos_d        = pos_q;
    duty_d       = duty_q;
    if (exec) begin
      case (op_i.kind)
        OP_TICK: begin
          if (status_q == ST_RUNNING || status_q == ST_MOVING) begin
            case (opc)
              OPC_WAIT: begin
                if (tick_q == arg) begin
                  idx_d  = idx_inc(idx_q);
                  tick_d = '0;
                end else begin
                  tick_d = tick_q + 5'd1;
                end
              end
              OPC_MOV: begin
                if (arg <= ARG_MAX_POSITION) begin
                  duty_d = duty_of(arg[2:0]);
                  if (tick_q == travel) begin
                    status_d = ST_RUNNING;
                    pos_d    = arg[2:0];
                    idx_d    = idx_inc(idx_q);
                    tick_d   = '0;
                  end else begin
                    status_d = ST_MOVING;
                    tick_d   = tick_q + 5'd1;
                  end
                end else begin
                  status_d = ST_CMD_ERR;
                end
              end
              OPC_LOOP: begin
                if (loop_act_q) begin
                  status_d = ST_LOOP_ERR;
                end else begin
                  loop_start_d = idx_q;
                  loop_rem_d   = arg;
                  loop_act_d   = 1'b1;
                  idx_d        = idx_inc(idx_q);
                end
              end
              OPC_ENDLOOP: begin
                // A stray end-of-loop acts on the counter just the same
                if (loop_rem_q == '0) begin
                  loop_act_d = 1'b0;
                  idx_d      = idx_inc(idx_q);
                end else begin
                  loop_rem_d = loop_rem_q - 5'd1;
                  idx_d      = idx_inc(loop_start_q);
                end
              end
              OPC_END: status_d = ST_FINISHED;
              default: status_d = ST_CMD_ERR;
            endcase
          end else if (status_q == ST_FORCED) begin
            if (nudge_q) begin
              nudge_d  = 1'b0;
              status_d = ST_PAUSED;
            end else begin
              nudge_d = 1'b1;
            end
          end
          case (status_d)
            ST_RUNNING:  begin green_d = 1'b1; red_d = 1'b0; end
            ST_PAUSED:   begin green_d = 1'b0; red_d = 1'b0; end
            ST_CMD_ERR:  begin green_d = 1'b0; red_d = 1'b1; end
            ST_LOOP_ERR: begin green_d = 1'b1; red_d = 1'b1; end
            default:     begin green_d = green_q; red_d = red_q; end
          endcase
        end
        OP_PAUSE: begin
          if (!(status_q inside {ST_CMD_ERR, ST_LOOP_ERR, ST_FINISHED})) begin
            status_d = ST_PAUSED;
          end
        end
        OP_CONTINUE: begin
          if (!(status_q inside {ST_CMD_ERR, ST_LOOP_ERR, ST_FINISHED})) begin
            status_d = ST_RUNNING;
          end
        end
        OP_RESTART: begin
          status_d = ST_RUNNING;
          idx_d    = '0;
        end
        OP_NUDGE_DOWN: begin
          if (status_q == ST_PAUSED && pos_q != POS_MIN && pos_q <= POS_MAX) begin
            status_d = ST_FORCED;
            pos_d    = pos_q - 3'd1;
            duty_d   = duty_of(pos_q - 3'd1);
          end
        end
        OP_NUDGE_UP: begin
          if (status_q == ST_PAUSED && pos_q < POS_MAX) begin
            status_d = ST_FORCED;
            pos_d    = pos_q + 3'd1;
            duty_d   = duty_of(pos_q + 3'd1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_o.status         = status_d;
    res_o.servo_position = pos_d;
    res_o.duty_code      = duty_d;
    res_o.green_led      = green_d;
    res_o.red_led        = red_d;
    res_o.recipe_index   = 6'(idx_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q     <= ST_PAUSED;
      idx_q        <= '0;
      loop_start_q <= '0;
      tick_q       <= '0;
      loop_rem_q   <= '0;
      loop_act_q   <= 1'b0;
      nudge_q      <= 1'b0;
      green_q      <= 1'b0;
      red_q        <= 1'b0;
      pos_q        <= '0;
      duty_q       <= '0;
    end else begin
      status_q     <= status_d;
      idx_q        <= idx_d;
      loop_start_q <= loop_start_d;
      tick_q       <= tick_d;
      loop_rem_q   <= loop_rem_d;
      loop_act_q   <= loop_act_d;
      nudge_q      <= nudge_d;
      green_q      <= green_d;
      red_q        <= red_d;
      pos_q        <= pos_d;
      duty_q       <= duty_d;
    end
  end

  // Recipe store: unwritten entries read as the end marker through the valid bits
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= op_i.data;
    end
    rd_q       <= mem_q[idx_d];
    fwd_data_q <= op_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[waddr] <= 1'b1;
      end
      rd_vld_q <= valid_q[idx_d];
      fwd_q    <= wr_en && (waddr == idx_d);
    end
  end

endmodule

>>> design/servo_recipe_sequencer_unit.sv
// Servo recipe sequencer: one servo channel stepping through a stored recipe.
// Input queue side: push/full with item_i. Each transaction is a recipe byte
//   write, a tick or a user key (p pause, c continue,
//   b restart, r/l nudge while paused). Every transaction yields one result.
// Result queue side: empty/pop with result_o giving status, servo position,
//   PWM duty code, the two lamps and the next recipe index.
// Order: a taken transaction is registered in the op queue, the executor runs
//   it from there, and its result is registered in the result queue, where
//   it shows on result_o and can be popped.
// Throughput: one transaction per cycle while the result queue has room. The
//   executor prefetches the recipe entry at the next index into a register,
//   so every tick finds its entry ready; the recipe memory read is registered.
// Stall: when pop stays low the result queue fills, the executor holds, the
//   op queue fills and full rises; nothing is dropped.
// Reset (rst_ni low, asynchronous): both queues empty, status paused, index,
//   counters, loop state, position, duty and lamps cleared. The recipe store
//   reads as all end markers through per-entry valid bits, no clearing pass.
// RECIPE_DEPTH must be a power of two; indexes and addresses wrap modulo it.
`include "servo_recipe_sequencer_unit_defines.svh"

module servo_recipe_sequencer_unit import srs_pkg::*; #(
  parameter int unsigned RECIPE_DEPTH = SRS_RECIPE_DEPTH,
  parameter int unsigned QUEUE_DEPTH  = SRS_QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  in_item_t  item_i,
  output logic      full,
  input  logic      pop,
  output res_item_t result_o,
  output logic      empty
);

  op_t                          op;
  logic                         op_empty, op_pop;
  logic                         res_full, res_push;
  res_item_t                    res;
  logic [$bits(res_item_t)-1:0] res_raw;

  // Front: take transactions and classify them into ops
  srs_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item_i),
    .full_o     (full),
    .op_pop_i   (op_pop),
    .op_o       (op),
    .op_empty_o (op_empty)
  );

  // Back: execute one op per cycle, while the result queue has room, against the recipe and servo state
  srs_back #(
    .RECIPE_DEPTH (RECIPE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .op_empty_i (op_empty),
    .op_pop_o   (op_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  // Result queue: decouple the executor from the consumer
  srs_fifo #(
    .WIDTH ($bits(res_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_raw),
    .empty_o (empty)
  );

  assign result_o = res_item_t'(res_raw);

  // Hold the executor while the result queue has no room
  `SRS_ASSERT_NOW(a_no_push_when_res_full, clk_i, rst_ni, res_full, !res_push)
  // An accepted transaction is waiting in the op queue on the next cycle
  `SRS_ASSERT_NEXT(a_accept_reaches_queue, clk_i, rst_ni, push && !full, !op_empty)
  // The servo never reports a position outside 0..5
  `SRS_ASSERT_NOW(a_position_in_range, clk_i, rst_ni, !empty, result_o.servo_position <= POS_MAX)

endmodule

>>> dv/servo_sequence_checker.sv
`timescale 1ns / 1ps

module servo_sequence_checker import srs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  in_item_t   item_i,
  input  logic       pop_i,
  input  logic       empty_i,
  input  res_item_t  result_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o,
  output logic [7:0] status_seen_o
);

  localparam int PRINT_CAP = 100;
  localparam logic [4:0] DUTY_LUT [6] = '{5'd4, 5'd7, 5'd10, 5'd14, 5'd17, 5'd20};

  // Shadow copy of the sequencer state
  logic [7:0] recipe_mem [SRS_RECIPE_DEPTH];
  logic [5:0] pc;
  logic [4:0] tick_cnt;
  logic [5:0] loop_base;
  logic [4:0] loop_left;
  logic       loop_on;
  status_e    run_st;
  logic [2:0] servo_pos;
  logic [4:0] duty;
  logic       settle;
  logic       green;
  logic       red;

  res_item_t wanted_q [$];
  int        fails;
  int        checked;
  logic [7:0] seen;

  function automatic void execute_recipe_entry();
    logic [7:0] entry;
    logic [4:0] arg;
    logic [2:0] span;
    entry = recipe_mem[pc];
    arg   = entry[4:0];
    case (entry[7:5])
      OPC_WAIT: begin
        if (tick_cnt == arg) begin
          pc++;
          tick_cnt = '0;
        end else begin
          tick_cnt++;
        end
      end
      OPC_MOV: begin
        if (arg <= ARG_MAX_POSITION) begin
          span = (arg[2:0] >= servo_pos) ? arg[2:0] - servo_pos : servo_pos - arg[2:0];
          duty = DUTY_LUT[arg[2:0]];
          // Travel takes two ticks per step
          if (tick_cnt == {1'b0, span, 1'b0}) begin
            run_st    = ST_RUNNING;
            servo_pos = arg[2:0];
            pc++;
            tick_cnt  = '0;
          end else begin
            run_st = ST_MOVING;
            tick_cnt++;
          end
        end else begin
          run_st = ST_CMD_ERR;
        end
      end
      OPC_LOOP: begin
        if (loop_on) begin
          run_st = ST_LOOP_ERR;
        end else begin
          loop_base = pc;
          loop_left = arg;
          loop_on   = 1'b1;
          pc++;
        end
      end
      OPC_ENDLOOP: begin
        if (loop_left == '0) begin
          loop_on = 1'b0;
          pc++;
        end else begin
          loop_left--;
          pc = loop_base + 6'd1;
        end
      end
      OPC_END: run_st = ST_FINISHED;
      default: run_st = ST_CMD_ERR;
    endcase
  endfunction

  function automatic void advance_tick();
    if (run_st == ST_RUNNING || run_st == ST_MOVING) begin
      execute_recipe_entry();
    end else if (run_st == ST_FORCED) begin
      if (settle) begin
        settle = 1'b0;
        run_st = ST_PAUSED;
      end else begin
        settle = 1'b1;
      end
    end
    // Lamps follow the status; moving, finished and forced move hold them
    case (run_st)
      ST_RUNNING:  begin green = 1'b1; red = 1'b0; end
      ST_PAUSED:   begin green = 1'b0; red = 1'b0; end
      ST_CMD_ERR:  begin green = 1'b0; red = 1'b1; end
      ST_LOOP_ERR: begin green = 1'b1; red = 1'b1; end
      default: ;
    endcase
  endfunction

  function automatic void apply_key(input logic [7:0] k);
    logic halted;
    halted = run_st inside {ST_CMD_ERR, ST_LOOP_ERR, ST_FINISHED};
    case (k)
      KEY_PAUSE_LC, KEY_PAUSE_UC: begin
        if (!halted) run_st = ST_PAUSED;
      end
      KEY_CONTINUE_LC, KEY_CONTINUE_UC: begin
        if (!halted) run_st = ST_RUNNING;
      end
      KEY_DOWN_LC, KEY_DOWN_UC: begin
        if (run_st == ST_PAUSED && servo_pos != POS_MIN && servo_pos <= POS_MAX) begin
          run_st = ST_FORCED;
          servo_pos--;
          duty = DUTY_LUT[servo_pos];
        end
      end
      KEY_UP_LC, KEY_UP_UC: begin
        if (run_st == ST_PAUSED && servo_pos < POS_MAX) begin
          run_st = ST_FORCED;
          servo_pos++;
          duty = DUTY_LUT[servo_pos];
        end
      end
      KEY_RESTART_LC, KEY_RESTART_UC: begin
        // Loop state and tick count survive a restart
        run_st = ST_RUNNING;
        pc     = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic res_item_t predict_response(input in_item_t it);
    res_item_t r;
    case (it.command)
      CMD_WRITE: recipe_mem[it.load_address] = it.load_byte;
      CMD_TICK:  advance_tick();
      CMD_KEY:   apply_key(it.key);
      default: ;
    endcase
    r.status         = run_st;
    r.servo_position = servo_pos;
    r.duty_code      = duty;
    r.green_led      = green;
    r.red_led        = red;
    r.recipe_index   = pc;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fails < PRINT_CAP) $display("%0t MISMATCH %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) report_mismatch($sformatf("%s: expected %0d, got %0d", name, want, got));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    res_item_t want;
    if (!rst_ni) begin
      foreach (recipe_mem[i]) recipe_mem[i] = '0;
      pc        = '0;
      tick_cnt  = '0;
      loop_base = '0;
      loop_left = '0;
      loop_on   = 1'b0;
      run_st    = ST_PAUSED;
      servo_pos = '0;
      duty      = '0;
      settle    = 1'b0;
      green     = 1'b0;
      red       = 1'b0;
      wanted_q.delete();
      fails     = 0;
      checked   = 0;
      seen      = '0;
    end else begin
      // Compare first: a result never belongs to a transaction taken at the same edge
      if (pop_i && !empty_i) begin
        if (wanted_q.size() == 0) begin
          report_mismatch("result arrived with no transaction outstanding");
        end else begin
          want = wanted_q.pop_front();
          check_field("status", want.status, result_i.status);
          check_field("servo_position", want.servo_position, result_i.servo_position);
          check_field("duty_code", want.duty_code, result_i.duty_code);
          check_field("green_led", want.green_led, result_i.green_led);
          check_field("red_led", want.red_led, result_i.red_led);
          check_field("recipe_index", want.recipe_index, result_i.recipe_index);
          seen[want.status] = 1'b1;
          checked++;
        end
      end
      if (push_i && !full_i) wanted_q.push_back(predict_response(item_i));
    end
    fail_count_o  <= fails;
    pending_o     <= wanted_q.size();
    checked_o     <= checked;
    status_seen_o <= seen;
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import srs_pkg::*;

  // Command code for an item the sequencer takes and does nothing with
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int RANDOM_ITEMS = 1550;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  item;
  logic      pop;
  logic      empty;
  res_item_t result;

  int         send_idle_pct;
  int         recv_idle_pct;
  int         items_sent;
  int         episodes;
  int         fail_count;
  int         pending;
  int         checked;
  logic [7:0] status_seen;

  servo_recipe_sequencer_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .item_i   (item),
    .full     (full),
    .pop      (pop),
    .result_o (result),
    .empty    (empty)
  );

  servo_sequence_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (full),
    .item_i        (item),
    .pop_i         (pop),
    .empty_i       (empty),
    .result_i      (result),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .status_seen_o (status_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: decide on each falling edge whether to take the next result
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // Offer one transaction, idling first at the current rate, and hold it
  // until the sequencer takes it. Enter and leave just after a falling edge.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk_i); while (full);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Randomize the fields a command ignores so every bit toggles
  function automatic in_item_t noise_item(input logic [1:0] cmd);
    in_item_t it;
    it = in_item_t'(24'($urandom));
    it.command = cmd;
    return it;
  endfunction

  task automatic do_write(input logic [5:0] addr, input logic [7:0] data);
    in_item_t it;
    it = noise_item(CMD_WRITE);
    it.load_address = addr;
    it.load_byte = data;
    send_item(it);
  endtask

  task automatic do_key(input logic [7:0] k);
    in_item_t it;
    it = noise_item(CMD_KEY);
    it.key = k;
    send_item(it);
  endtask

  task automatic do_tick();
    send_item(noise_item(CMD_TICK));
  endtask

  task automatic do_nop();
    send_item(noise_item(CMD_NOP));
  endtask

  // Draw a key from a slice of the list: 0..3 nudges, 4..5 pause,
  // 6..7 continue, 8..9 restart
  function automatic logic [7:0] pick_key(input int lo, input int hi);
    case ($urandom_range(lo, hi))
      0: return KEY_DOWN_LC;
      1: return KEY_DOWN_UC;
      2: return KEY_UP_LC;
      3: return KEY_UP_UC;
      4: return KEY_PAUSE_LC;
      5: return KEY_PAUSE_UC;
      6: return KEY_CONTINUE_LC;
      7: return KEY_CONTINUE_UC;
      8: return KEY_RESTART_LC;
      default: return KEY_RESTART_UC;
    endcase
  endfunction

  // Break into a running recipe: user keys, idle commands, stray writes
  task automatic disturb();
    case ($urandom_range(9))
      0, 1, 2: begin
        // Pause, nudge, let the servo settle, then carry on
        do_key(pick_key(4, 5));
        do_key(pick_key(0, 3));
        repeat ($urandom_range(1, 3)) do_tick();
        do_key(pick_key(6, 7));
      end
      3: do_key(pick_key(8, 9));
      4: begin
        do_key(pick_key(4, 5));
        repeat ($urandom_range(1, 3)) do_tick();
        do_key(pick_key(6, 7));
      end
      5: do_key(8'($urandom));
      6: do_nop();
      7: do_write(6'($urandom), 8'($urandom));
      8: do_key(pick_key(0, 9));
      default: do_key(pick_key(6, 7));
    endcase
  endtask

  // Load a recipe at index 0, restart it and tick it through, with the odd
  // interruption. Most recipes are well formed; some carry junk bytes.
  task automatic run_episode(input int ep);
    logic [7:0] prog [$];
    logic [4:0] arg;
    int budget;
    int reps;
    int body_cost;
    int pick;
    budget = 0;
    if (ep % 14 == 9) begin
      // Fill the whole store with no end marker so the index wraps past the top
      for (int a = 0; a < SRS_RECIPE_DEPTH; a++) begin
        if ($urandom_range(15) == 0) begin
          prog.push_back({OPC_MOV, 5'($urandom_range(5))});
          budget += 11;
        end else begin
          prog.push_back({OPC_WAIT, 5'd0});
          budget += 1;
        end
      end
      budget += 12;
    end else begin
      // Lead with an unmatched end-of-loop now and then; it drops a stale loop flag when the counter is zero
      if ($urandom_range(99) < 15) begin
        prog.push_back({OPC_ENDLOOP, 5'($urandom)});
        budget++;
      end
      repeat ($urandom_range(1, 6)) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          prog.push_back({OPC_MOV, 5'($urandom_range(5))});
          budget += 11;
        end else if (pick < 70) begin
          arg = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(3));
          prog.push_back({OPC_WAIT, arg});
          budget += int'(arg) + 1;
        end else if (pick < 90) begin
          reps = $urandom_range(3);
          prog.push_back({OPC_LOOP, 5'(reps)});
          body_cost = 1;
          repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(1) == 1) begin
              prog.push_back({OPC_MOV, 5'($urandom_range(5))});
              body_cost += 11;
            end else begin
              prog.push_back({OPC_WAIT, 5'($urandom_range(2))});
              body_cost += 3;
            end
          end
          prog.push_back({OPC_ENDLOOP, 5'($urandom)});
          budget += (reps + 1) * body_cost + 1;
        end else begin
          prog.push_back(8'($urandom));
          budget++;
        end
      end
      prog.push_back({OPC_END, 5'($urandom)});
      budget++;
      if (budget > 90) budget = 90;
    end
    foreach (prog[a]) do_write(6'(a), prog[a]);
    do_key(pick_key(8, 9));
    budget += $urandom_range(4);
    repeat (budget) begin
      if ($urandom_range(99) < 85) do_tick();
      else disturb();
    end
  endtask

  initial begin : stimulus
    int base;
    rst_ni = 1'b0;
    push = 1'b0;
    item = '0;
    items_sent = 0;
    episodes = 0;
    send_idle_pct = 32;
    recv_idle_pct = 60;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, every command, the error paths, nudges
    do_write(6'd63, {OPC_WAIT, 5'd1});
    do_write(6'd0, 8'hFF);
    do_nop();
    do_key(8'h00);
    do_tick();                         // paused: nothing runs
    do_key(KEY_CONTINUE_LC);
    do_tick();                         // unknown opcode -> command error
    do_key(KEY_PAUSE_UC);              // ignored once stopped
    do_write(6'd0, {OPC_MOV, 5'd6});
    do_key(KEY_RESTART_UC);
    do_tick();                         // move past the last position
    do_write(6'd0, {OPC_LOOP, 5'd0});
    do_write(6'd1, {OPC_LOOP, 5'd31});
    do_key(KEY_RESTART_LC);
    do_tick();
    do_tick();                         // loop inside a loop -> loop error
    do_write(6'd0, {OPC_ENDLOOP, 5'd0});
    do_write(6'd1, 8'h00);
    do_key(KEY_RESTART_LC);
    do_tick();                         // end-of-loop drops the flag, restart kept it
    do_tick();                         // end marker -> finished
    do_key(KEY_RESTART_LC);
    do_key(KEY_PAUSE_LC);
    do_key(KEY_UP_LC);
    do_tick();
    do_tick();                         // forced move settles back to paused
    do_key(KEY_DOWN_LC);
    do_key(KEY_DOWN_UC);               // ignored while the forced move settles

    // Random: three idling profiles, the last with no idling at all
    base = items_sent;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 60 : 0;
      recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 32 : 0;
      while (items_sent - base < RANDOM_ITEMS * (ph + 1) / 3) begin
        run_episode(episodes);
        episodes++;
      end
    end
    push <= 1'b0;

    // Drain: wait for every predicted result, then a quiet spell of DRAIN_CYCLES
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d transactions over %0d recipe episodes; %0d results compared.",
             items_sent, episodes, checked);
    $display("Status codes reached, one bit per code: %b", status_seen);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
